@@ hdl/ksi_pkg.sv @@
package ksi_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [23:0]        item_index;
    logic signed [31:0] item_value;
    logic [7:0]         read_slot;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [7:0]         placed_slot;
    logic               slot_valid;
    logic signed [31:0] slot_value;
    logic [23:0]        slot_tag;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [23:0]        tag;
  } entry_t;

endpackage

@@ hdl/k_smallest_sorted_insert_core.sv @@
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data  (ksi_pkg::in_item_t)
// out       output     out_valid / out_stall out_data (ksi_pkg::out_item_t)
//
// One item is worked on at a time. An insert walks down the entry memory from the
// top kept entry, one entry per cycle through its single read port, until it finds
// the place for the new value (or drops it). A read of a filled slot goes through
// S_RDW; clear, the unused op and an empty-slot read go to S_DONE. Reset empties the
// list at once through the fill count. A waiting result does not block the next item;
// only the last step of an item waits while the output register is held by out_stall.
module k_smallest_sorted_insert_core #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ksi_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ksi_pkg::out_item_t  out_data
);
  import ksi_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int FW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_RDW   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  in_item_t    in_r, in_nxt;
  out_item_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  entry_t      mem [SLOTS];
  entry_t      rd_data_r;
  logic [AW-1:0] rd_addr;
  logic        we;
  logic [AW-1:0] wa;
  entry_t      wd;

  logic        accept;
  logic [AW:0] idx_up;
  logic        le;
  logic        full;
  logic [FW-1:0] fill_inc;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign idx_up   = {1'b0, idx_r} + 1'b1;
  assign le       = ($signed(rd_data_r.value) <= $signed(in_r.item_value));
  assign full     = (fill_r == FW'(SLOTS));
  assign fill_inc = full ? fill_r : fill_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    in_nxt        = in_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_addr       = '0;
    we            = 1'b0;
    wa            = '0;
    wd            = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt  = in_data;
          res_nxt = '0;
          state_nxt = S_DONE;
          unique case (in_data.op)
            OP_INSERT: begin
              if (fill_r == '0) begin
                state_nxt = S_PLACE;
              end else begin
                idx_nxt   = AW'(fill_r - 1'b1);
                rd_addr   = AW'(fill_r - 1'b1);
                state_nxt = S_CMP;
              end
            end
            OP_CLEAR: begin
              fill_nxt = '0;
            end
            OP_READ: begin
              if ({1'b0, in_data.read_slot} < 9'(fill_r)) begin
                rd_addr   = AW'(in_data.read_slot);
                state_nxt = S_RDW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CMP: begin
        if (le) begin
          // New value goes right after the last entry that is not above it.
          if (idx_up == (AW + 1)'(SLOTS)) begin
            state_nxt = S_DONE;
          end else begin
            we       = 1'b1;
            wa       = idx_up[AW-1:0];
            wd.value = in_r.item_value;
            wd.tag   = in_r.item_index;
            fill_nxt = fill_inc;
            res_nxt.accepted    = 1'b1;
            res_nxt.placed_slot = 8'(idx_up);
            state_nxt = S_DONE;
          end
        end else begin
          // Shift this entry up; the top one falls off when the list is full.
          we = (idx_up != (AW + 1)'(SLOTS));
          wa = idx_up[AW-1:0];
          wd = rd_data_r;
          if (idx_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            idx_nxt = idx_r - 1'b1;
            rd_addr = idx_r - 1'b1;
          end
        end
      end
      S_PLACE: begin
        we       = 1'b1;
        wa       = '0;
        wd.value = in_r.item_value;
        wd.tag   = in_r.item_index;
        fill_nxt = fill_inc;
        res_nxt.accepted    = 1'b1;
        res_nxt.placed_slot = '0;
        state_nxt = S_DONE;
      end
      S_RDW: begin
        res_nxt.slot_valid = 1'b1;
        res_nxt.slot_value = rd_data_r.value;
        res_nxt.slot_tag   = rd_data_r.tag;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    in_r       <= in_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(SLOTS))
    else $error("fill count exceeds the number of slots");

  a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ({1'b0, idx_r} < (AW + 1)'(fill_r)))
    else $error("insert scan left the filled part of the list");

  a_placed_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.accepted) |-> (9'(res_r.placed_slot) < 9'(fill_r)))
    else $error("placed slot lies beyond the fill level");

  a_insert_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r.accepted) |-> !res_r.slot_valid)
    else $error("insert result carries read data");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted item produced no work");

endmodule
